### rtl/core/dataset_overlap_average_macros.svh
// Assertion macros shared by the overlap average block.
`ifndef DATASET_OVERLAP_AVERAGE_MACROS_SVH
`define DATASET_OVERLAP_AVERAGE_MACROS_SVH
`ifndef SYNTHESIS
`define DOA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DOA_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DOA_ASSERT(lbl, clk, rst, prop, msg)
`define DOA_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### rtl/core/doa_pkg.sv
// Types and constants of the overlap average block.
package doa_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [30:0] THRESHOLD_RESET = 31'd1;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_ZERO  = 2'd1;
  localparam logic [1:0] KIND_TERM  = 2'd2;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_STEPS = 33;

  localparam logic [32:0] Q_ONE          = 33'h0_0001_0000;
  localparam logic [32:0] TERM_POS_LIMIT = 33'h0_8001_0000;
  localparam logic [32:0] TERM_NEG_LIMIT = 33'h0_7FFE_FFFF;
  localparam logic [32:0] MEAN_NEG_LIMIT = 33'h0_8000_0000;
  localparam logic [32:0] MEAN_POS_LIMIT = 33'h0_7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic        den_neg;
    logic [32:0] diff_mag;
    logic [32:0] den_mag;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic                 ovf;
    logic [DIV_STEPS-1:0] quo;
  } div_res_t;

endpackage

### rtl/core/dataset_overlap_average.sv
// Overlap average of two paired Q16.16 data sets.
//
// Input stream s_*: one transfer per sample pair, tdata = {value_b, value_a},
// tlast marks the final pair of a data set. Output stream m_*: one transfer
// per data set, tdata = {zeros, points_empty, points_used, overlap}.
// cfg_*: write of small_threshold (31 bits), always ready; write it only
// while the block is idle.
// Pairs are classified on arrival and held in a two-entry queue; the back
// end takes one pair at a time. A pair with a quotient term occupies the
// back end for a pop, a divider range check, 33 radix-2 steps and the add
// of the term; a skipped or zero-term pair needs only the pop. After the
// final pair the back end runs the mean divide and registers the result
// (zero, with no divide, when no pair was counted). The input keeps accepting
// while the queue has room, also while a result waits on a stalled receiver;
// the back end holds only when it has a new result and the output register
// is still full.
// Reset clears the sums, the counts, the queue and the output valid and
// sets small_threshold to one LSB; no clearing pass follows.
module dataset_overlap_average #(
  parameter int COUNT_BITS = doa_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // value_a [31:0], value_b [63:32]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // overlap [31:0], points_used [56:32], points_empty [81:57]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data   // small_threshold [30:0]
);

  logic [30:0]       small_threshold;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  doa_pkg::entry_t   q_entry;
  doa_pkg::entry_t   q_head;
  doa_pkg::div_req_t div_req;
  doa_pkg::div_res_t div_res;
  logic [31:0]       overlap;
  logic [24:0]       points_used;
  logic [24:0]       points_empty;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {6'd0, points_empty, points_used, overlap};

  always_ff @(posedge clk) begin
    if (rst) begin
      small_threshold <= doa_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      small_threshold <= cfg_data;
    end
  end

  doa_front u_front (
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .value_a         (s_tdata[31:0]),
    .value_b         (s_tdata[63:32]),
    .last            (s_tlast),
    .small_threshold (small_threshold),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  doa_queue #(
    .DEPTH (doa_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  doa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  doa_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .div_req      (div_req),
    .div_res      (div_res),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .overlap      (overlap),
    .points_used  (points_used),
    .points_empty (points_empty)
  );

endmodule

### rtl/core/doa_front.sv
// Front end: accept sample pairs and classify them for the queue.
module doa_front (
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      value_a,
  input  logic [31:0]      value_b,
  input  logic             last,
  input  logic [30:0]      small_threshold,
  input  logic             q_full,
  output logic             q_push,
  output doa_pkg::entry_t  q_entry
);

  logic [32:0] a_ext;
  logic [32:0] b_ext;
  logic [32:0] a_mag;
  logic [32:0] b_mag;
  logic [32:0] den;
  logic [32:0] diff;
  logic [32:0] den_mag;
  logic [32:0] diff_mag;
  logic [32:0] thr_ext;
  logic        is_empty;
  logic        is_zero;

  always_comb begin
    a_ext    = {value_a[31], value_a};
    b_ext    = {value_b[31], value_b};
    a_mag    = value_a[31] ? (33'd0 - a_ext) : a_ext;
    b_mag    = value_b[31] ? (33'd0 - b_ext) : b_ext;
    den      = a_ext + b_ext;
    diff     = a_ext - b_ext;
    den_mag  = den[32] ? (33'd0 - den) : den;
    diff_mag = diff[32] ? (33'd0 - diff) : diff;
    thr_ext  = {2'b00, small_threshold};
    is_empty = (a_mag < thr_ext) && (b_mag < thr_ext);
    is_zero  = (den == 33'd0) || (den_mag < thr_ext);
  end

  always_comb begin
    s_tready         = !q_full;
    q_push           = s_tvalid && !q_full;
    q_entry.last     = last;
    q_entry.den_neg  = den[32];
    q_entry.diff_mag = diff_mag;
    q_entry.den_mag  = den_mag;
    if (is_empty) begin
      q_entry.kind = doa_pkg::KIND_EMPTY;
    end else if (is_zero) begin
      q_entry.kind = doa_pkg::KIND_ZERO;
    end else begin
      q_entry.kind = doa_pkg::KIND_TERM;
    end
  end

endmodule

### rtl/core/doa_queue.sv
// Short queue of classified pairs between front and back end.
`include "dataset_overlap_average_macros.svh"
module doa_queue #(
  parameter int DEPTH = doa_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  doa_pkg::entry_t push_entry,
  input  logic            pop,
  output doa_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  doa_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_comb begin
    full  = (count == CNT_W'(DEPTH));
    empty = (count == '0);
    head  = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DOA_ASSERT_NEVER(a_no_overflow, clk, rst, push && full, "push into full queue")
  `DOA_ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty, "pop from empty queue")

endmodule

### rtl/core/doa_div.sv
// Radix-2 restoring divider with a 33-bit quotient and overflow flag.
`include "dataset_overlap_average_macros.svh"
module doa_div (
  input  logic              clk,
  input  logic              rst,
  input  doa_pkg::div_req_t req,
  output doa_pkg::div_res_t res
);

  localparam logic [1:0] DV_IDLE  = 2'd0;
  localparam logic [1:0] DV_CHECK = 2'd1;
  localparam logic [1:0] DV_RUN   = 2'd2;

  localparam int NW = doa_pkg::DIV_NUM_W;
  localparam int DW = doa_pkg::DIV_DEN_W;
  localparam int QW = doa_pkg::DIV_STEPS;
  localparam int CW = $clog2(QW);

  logic [1:0]    state;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem;
  logic [QW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          ovf_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          ge;
  logic          too_big;

  always_comb begin
    trial   = {rem, quo[QW-1]};
    ge      = (trial >= {1'b0, den_r});
    too_big = ({2'b00, num_r} >= {den_r, {QW{1'b0}}});
    res.busy = (state != DV_IDLE);
    res.done = done_r;
    res.ovf  = ovf_r;
    res.quo  = quo;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DV_IDLE: begin
        if (req.start) begin
          num_r <= req.num;
          den_r <= req.den;
        end
      end
      DV_CHECK: begin
        ovf_r <= too_big;
        rem   <= DW'(num_r[NW-1:QW]);
        quo   <= num_r[QW-1:0];
        cnt   <= '0;
      end
      DV_RUN: begin
        rem <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= DV_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (req.start) begin
            state <= DV_CHECK;
          end
        end
        DV_CHECK: begin
          if (too_big) begin
            done_r <= 1'b1;
            state  <= DV_IDLE;
          end else begin
            state <= DV_RUN;
          end
        end
        DV_RUN: begin
          if (cnt == CW'(QW - 1)) begin
            done_r <= 1'b1;
            state  <= DV_IDLE;
          end
        end
        default: begin
          state <= DV_IDLE;
        end
      endcase
    end
  end

  `DOA_ASSERT(a_rem_below, clk, rst, state == DV_RUN |-> rem < den_r, "remainder not below divisor")
  `DOA_ASSERT(a_done_after_work, clk, rst, done_r |-> $past(state) != DV_IDLE, "done without work")

endmodule

### rtl/core/doa_back.sv
// Back end: accumulate terms, count pairs and emit the mean on the last pair.
`include "dataset_overlap_average_macros.svh"
module doa_back #(
  parameter int COUNT_BITS = doa_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  doa_pkg::entry_t   q_head,
  output logic              q_pop,
  output doa_pkg::div_req_t div_req,
  input  doa_pkg::div_res_t div_res,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       overlap,
  output logic [24:0]       points_used,
  output logic [24:0]       points_empty
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TERM   = 3'd1;
  localparam logic [2:0] ST_FINISH = 3'd2;
  localparam logic [2:0] ST_MEAN   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  localparam int CNT_W = COUNT_BITS + 1;

  logic [2:0]       state;
  logic [63:0]      term_sum;
  logic [CNT_W-1:0] used_count;
  logic [CNT_W-1:0] empty_count;
  logic             den_neg_r;
  logic             last_r;
  logic             sum_neg_r;
  logic [31:0]      res_r;
  logic             used_sat;
  logic             empty_sat;
  logic             out_free;
  logic [63:0]      sum_mag;
  logic [31:0]      term_val;
  logic [31:0]      mean_val;

  always_comb begin
    used_sat  = used_count[COUNT_BITS];
    empty_sat = empty_count[COUNT_BITS];
    out_free  = !m_tvalid || m_tready;
    sum_mag   = term_sum[63] ? (64'd0 - term_sum) : term_sum;
    q_pop     = (state == ST_IDLE) && !q_empty;

    if (den_neg_r) begin
      term_val = (div_res.ovf || div_res.quo > doa_pkg::TERM_NEG_LIMIT) ? 32'h7FFF_FFFF
               : 32'(doa_pkg::Q_ONE + div_res.quo);
    end else begin
      term_val = (div_res.ovf || div_res.quo > doa_pkg::TERM_POS_LIMIT) ? 32'h8000_0000
               : 32'(doa_pkg::Q_ONE - div_res.quo);
    end

    if (sum_neg_r) begin
      mean_val = (div_res.ovf || div_res.quo > doa_pkg::MEAN_NEG_LIMIT) ? 32'h8000_0000
               : 32'(33'd0 - div_res.quo);
    end else begin
      mean_val = (div_res.ovf || div_res.quo > doa_pkg::MEAN_POS_LIMIT) ? 32'h7FFF_FFFF
               : div_res.quo[31:0];
    end

    div_req.start = 1'b0;
    div_req.num   = {15'd0, q_head.diff_mag, 16'd0};
    div_req.den   = q_head.den_mag;
    if (state == ST_FINISH) begin
      div_req.num   = sum_mag;
      div_req.den   = doa_pkg::DIV_DEN_W'(used_count);
      div_req.start = (used_count != '0);
    end else if (q_pop && q_head.kind == doa_pkg::KIND_TERM && !used_sat) begin
      div_req.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      term_sum    <= '0;
      used_count  <= '0;
      empty_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            last_r    <= q_head.last;
            den_neg_r <= q_head.den_neg;
            state     <= q_head.last ? ST_FINISH : ST_IDLE;
            unique case (q_head.kind)
              doa_pkg::KIND_EMPTY: begin
                if (!empty_sat) begin
                  empty_count <= empty_count + 1'b1;
                end
              end
              doa_pkg::KIND_ZERO: begin
                if (!used_sat) begin
                  used_count <= used_count + 1'b1;
                end
              end
              doa_pkg::KIND_TERM: begin
                if (!used_sat) begin
                  used_count <= used_count + 1'b1;
                  state      <= ST_TERM;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_TERM: begin
          if (div_res.done) begin
            term_sum <= term_sum + {{32{term_val[31]}}, term_val};
            state    <= last_r ? ST_FINISH : ST_IDLE;
          end
        end
        ST_FINISH: begin
          sum_neg_r <= term_sum[63];
          if (used_count == '0) begin
            res_r <= '0;
            state <= ST_EMIT;
          end else begin
            state <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (div_res.done) begin
            res_r <= mean_val;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            term_sum    <= '0;
            used_count  <= '0;
            empty_count <= '0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      overlap      <= res_r;
      points_used  <= 25'(used_count);
      points_empty <= 25'(empty_count);
    end
  end

  `DOA_ASSERT(a_div_free, clk, rst, div_req.start |-> !div_res.busy, "divider started while busy")
  `DOA_ASSERT_NEVER(a_used_cap, clk, rst, used_sat && (|used_count[COUNT_BITS-1:0]), "used count past cap")
  `DOA_ASSERT_NEVER(a_empty_cap, clk, rst, empty_sat && (|empty_count[COUNT_BITS-1:0]), "empty count past cap")
  `DOA_ASSERT(a_clear, clk, rst, (state == ST_EMIT && out_free) |=> (m_tvalid && used_count == '0 && empty_count == '0 && term_sum == '0), "state not cleared after result")

endmodule
